// ===== hw/rtl/bq_pkg.sv =====
// Shared constants, control types and saturation helpers for the stereo biquad filter.
package bq_pkg;

  // Fixed-point formats
  localparam int SAMPLE_BITS     = 24;
  localparam int COEFF_FRAC_BITS = 28;
  localparam int COEFF_BITS      = 32;
  localparam int STATE_BITS      = 32;
  localparam int PROD_BITS       = 2 * COEFF_BITS;
  localparam int ACC_BITS        = PROD_BITS + 2;
  localparam int SHIFT_BITS      = ACC_BITS - COEFF_FRAC_BITS;
  localparam int DIFF_BITS       = SHIFT_BITS + 2;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd4;

  // Multiplier data operand select
  localparam logic [1:0] DSEL_W1 = 2'd0;
  localparam logic [1:0] DSEL_W2 = 2'd1;
  localparam logic [1:0] DSEL_W  = 2'd2;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  // Per-cycle control from the sequencer to the datapath
  typedef struct packed {
    logic [CFG_IDX_BITS-1:0] coef_sel;
    logic [1:0]              data_sel;
    logic [1:0]              acc_op;
    logic                    w_en;
    logic                    y_en;
    logic                    ch;
    logic                    last;
  } ctl_t;

  // Clamp a difference to the delay-state range
  function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [DIFF_BITS-1:0] v);
    logic signed [DIFF_BITS-1:0] hi;
    logic signed [DIFF_BITS-1:0] lo;
    hi = DIFF_BITS'({1'b0, {(STATE_BITS-1){1'b1}}});
    lo = -hi - DIFF_BITS'(1);
    if (v > hi) return hi[STATE_BITS-1:0];
    else if (v < lo) return lo[STATE_BITS-1:0];
    else return v[STATE_BITS-1:0];
  endfunction

  // Clamp a scaled sum to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [SHIFT_BITS-1:0] v);
    logic signed [SHIFT_BITS-1:0] hi;
    logic signed [SHIFT_BITS-1:0] lo;
    hi = SHIFT_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    lo = -hi - SHIFT_BITS'(1);
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    else if (v < lo) return lo[SAMPLE_BITS-1:0];
    else return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/bq_in_if.sv =====
// Input channel: one stereo sample pair with its block end mark.
interface bq_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bq_pkg::SAMPLE_BITS-1:0]   left_smp;
  logic signed [bq_pkg::SAMPLE_BITS-1:0]   right_smp;
  logic                                    block_end_in;

  modport source (output valid, output left_smp, output right_smp, output block_end_in,
                  input ready);
  modport sink   (input valid, input left_smp, input right_smp, input block_end_in,
                  output ready);
endinterface

// ===== hw/rtl/bq_out_if.sv =====
// Result channel: one filtered stereo sample pair with its block end mark.
interface bq_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bq_pkg::SAMPLE_BITS-1:0]   left_flt;
  logic signed [bq_pkg::SAMPLE_BITS-1:0]   right_flt;
  logic                                    block_end_out;

  modport source (output valid, output left_flt, output right_flt, output block_end_out,
                  input ready);
  modport sink   (input valid, input left_flt, input right_flt, input block_end_out,
                  output ready);
endinterface

// ===== hw/rtl/bq_mac.sv =====
// Shared multiply-accumulate unit: registered 32x32 product and a wide accumulator.
module bq_mac (
  input  logic                                 clk,
  input  logic signed [bq_pkg::COEFF_BITS-1:0] op_a,
  input  logic signed [bq_pkg::STATE_BITS-1:0] op_b,
  input  logic [1:0]                           acc_op,
  output logic signed [bq_pkg::ACC_BITS-1:0]   acc
);

  logic signed [bq_pkg::PROD_BITS-1:0] prod_r;
  logic signed [bq_pkg::ACC_BITS-1:0]  acc_r;

  // Register the product
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // Load, add or hold the previous product
  always_ff @(posedge clk) begin
    unique case (acc_op)
      bq_pkg::ACC_LOAD: acc_r <= bq_pkg::ACC_BITS'(prod_r);
      bq_pkg::ACC_ADD:  acc_r <= acc_r + bq_pkg::ACC_BITS'(prod_r);
      default:          acc_r <= acc_r;
    endcase
  end

  assign acc = acc_r;

endmodule

// ===== hw/rtl/bq_seq.sv =====
// Step sequencer: walks both channels through the multiply-accumulate schedule.
module bq_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          stall,
  output logic          busy,
  output bq_pkg::ctl_t  ctl
);

  localparam logic [3:0] PH_A1  = 4'd0;
  localparam logic [3:0] PH_A2  = 4'd1;
  localparam logic [3:0] PH_FA  = 4'd2;
  localparam logic [3:0] PH_W   = 4'd3;
  localparam logic [3:0] PH_B0  = 4'd4;
  localparam logic [3:0] PH_B1  = 4'd5;
  localparam logic [3:0] PH_B2  = 4'd6;
  localparam logic [3:0] PH_FB  = 4'd7;
  localparam logic [3:0] PH_Y   = 4'd8;

  logic [3:0] phase_r, phase_nxt;
  logic       ch_r, ch_nxt;
  logic       busy_r, busy_nxt;
  logic       last;

  assign last = busy_r && ch_r && (phase_r == PH_Y);

  // Advance through phases, left channel then right
  always_comb begin
    phase_nxt = phase_r;
    ch_nxt    = ch_r;
    busy_nxt  = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt  = 1'b1;
        phase_nxt = PH_A1;
        ch_nxt    = 1'b0;
      end
    end else if (phase_r == PH_Y) begin
      if (!ch_r) begin
        ch_nxt    = 1'b1;
        phase_nxt = PH_A1;
      end else if (!stall) begin
        busy_nxt = 1'b0;
      end
    end else begin
      phase_nxt = phase_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_A1;
      ch_r    <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      ch_r    <= ch_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // Decode the phase into datapath control
  always_comb begin
    ctl          = '0;
    ctl.coef_sel = bq_pkg::REG_A1;
    ctl.data_sel = bq_pkg::DSEL_W1;
    ctl.acc_op   = bq_pkg::ACC_HOLD;
    ctl.ch       = ch_r;
    ctl.last     = last;
    if (busy_r) begin
      unique case (phase_r)
        PH_A1: begin
          ctl.coef_sel = bq_pkg::REG_A1;
          ctl.data_sel = bq_pkg::DSEL_W1;
        end
        PH_A2: begin
          ctl.coef_sel = bq_pkg::REG_A2;
          ctl.data_sel = bq_pkg::DSEL_W2;
          ctl.acc_op   = bq_pkg::ACC_LOAD;
        end
        PH_FA: ctl.acc_op = bq_pkg::ACC_ADD;
        PH_W:  ctl.w_en   = 1'b1;
        PH_B0: begin
          ctl.coef_sel = bq_pkg::REG_B0;
          ctl.data_sel = bq_pkg::DSEL_W;
        end
        PH_B1: begin
          ctl.coef_sel = bq_pkg::REG_B1;
          ctl.data_sel = bq_pkg::DSEL_W1;
          ctl.acc_op   = bq_pkg::ACC_LOAD;
        end
        PH_B2: begin
          ctl.coef_sel = bq_pkg::REG_B2;
          ctl.data_sel = bq_pkg::DSEL_W2;
          ctl.acc_op   = bq_pkg::ACC_ADD;
        end
        PH_FB: ctl.acc_op = bq_pkg::ACC_ADD;
        PH_Y:  ctl.y_en   = !(ch_r && stall);
        default: ctl.acc_op = bq_pkg::ACC_HOLD;
      endcase
    end
  end

  assign busy = busy_r;

endmodule

// ===== hw/rtl/stereo_biquad_iir_df2.sv =====
// Stereo biquad IIR filter, direct form II, with one shared multiply-accumulate unit.
//
// Usage:
//   in_ch carries a left/right sample pair (signed 24-bit) and a block end mark.
//   out_ch returns the filtered pair, saturated to 24 bits, and the same mark.
//   cfg_wr_en/cfg_index/cfg_wdata load a1, a2, b0, b1, b2 (Q3.28, index 0..4);
//   other indexes are dropped. Write coefficients only while the block is idle.
// Timing:
//   After an input transfer the sequencer runs nine steps per channel through
//   one 32x32 multiplier and a 66-bit accumulator. The result is valid on
//   out_ch on the cycle after the last step, and in_ch.ready rises at the
//   same time; in_ch takes no new pair while the sequencer is busy.
//   The shared multiplier, used five times per channel, sets the stream rate.
// Reset:
//   Synchronous, active low. Clears the four delay registers, sets b0 to one
//   (passthrough) and the other coefficients to zero, and empties the output.
// Backpressure:
//   The output register holds a result until it is taken. A new pair may be
//   accepted meanwhile; its last step waits until the output register is free.
module stereo_biquad_iir_df2 (
  input  logic                                clk,
  input  logic                                rst_n,
  bq_in_if.sink                               in_ch,
  bq_out_if.source                            out_ch,
  input  logic                                cfg_wr_en,
  input  logic [bq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bq_pkg::COEFF_BITS-1:0]       cfg_wdata
);

  logic signed [bq_pkg::COEFF_BITS-1:0]  a1_r, a2_r, b0_r, b1_r, b2_r;
  logic signed [bq_pkg::STATE_BITS-1:0]  lw1_r, lw2_r, rw1_r, rw2_r, w_r;
  logic signed [bq_pkg::SAMPLE_BITS-1:0] left_r, right_r, left_y_r;
  logic                                  end_r;
  logic signed [bq_pkg::SAMPLE_BITS-1:0] out_left_r, out_right_r;
  logic                                  out_end_r;
  logic                                  out_valid_r, out_valid_nxt;

  logic                                  busy, stall, in_xfer, out_xfer, out_load;
  bq_pkg::ctl_t                          ctl;
  logic signed [bq_pkg::COEFF_BITS-1:0]  op_a;
  logic signed [bq_pkg::STATE_BITS-1:0]  op_b, w1_sel, w2_sel;
  logic signed [bq_pkg::ACC_BITS-1:0]    acc;
  logic signed [bq_pkg::SHIFT_BITS-1:0]  acc_sh;
  logic signed [bq_pkg::SAMPLE_BITS-1:0] x_sel, y_sat;
  logic signed [bq_pkg::DIFF_BITS-1:0]   w_diff;

  assign in_ch.ready = !busy;
  assign in_xfer     = in_ch.valid && !busy;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign stall       = out_valid_r && !out_ch.ready;
  assign out_load    = ctl.last && ctl.y_en;

  bq_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .stall (stall),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_r <= '0;
      a2_r <= '0;
      b0_r <= bq_pkg::COEFF_BITS'(1) << bq_pkg::COEFF_FRAC_BITS;
      b1_r <= '0;
      b2_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bq_pkg::REG_A1: a1_r <= cfg_wdata;
        bq_pkg::REG_A2: a2_r <= cfg_wdata;
        bq_pkg::REG_B0: b0_r <= cfg_wdata;
        bq_pkg::REG_B1: b1_r <= cfg_wdata;
        bq_pkg::REG_B2: b2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the input pair on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      left_r  <= in_ch.left_smp;
      right_r <= in_ch.right_smp;
      end_r   <= in_ch.block_end_in;
    end
  end

  // Operand selection for the shared multiplier
  assign w1_sel = ctl.ch ? rw1_r : lw1_r;
  assign w2_sel = ctl.ch ? rw2_r : lw2_r;
  assign x_sel  = ctl.ch ? right_r : left_r;

  always_comb begin
    case (ctl.coef_sel)
      bq_pkg::REG_A1: op_a = a1_r;
      bq_pkg::REG_A2: op_a = a2_r;
      bq_pkg::REG_B0: op_a = b0_r;
      bq_pkg::REG_B1: op_a = b1_r;
      bq_pkg::REG_B2: op_a = b2_r;
      default:        op_a = '0;
    endcase
    case (ctl.data_sel)
      bq_pkg::DSEL_W1: op_b = w1_sel;
      bq_pkg::DSEL_W2: op_b = w2_sel;
      bq_pkg::DSEL_W:  op_b = w_r;
      default:         op_b = '0;
    endcase
  end

  bq_mac u_mac (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .acc_op (ctl.acc_op),
    .acc    (acc)
  );

  // Floor-scale the sum, form w and y with saturation
  assign acc_sh = acc[bq_pkg::ACC_BITS-1:bq_pkg::COEFF_FRAC_BITS];
  assign w_diff = bq_pkg::DIFF_BITS'(x_sel) - bq_pkg::DIFF_BITS'(acc_sh);
  assign y_sat  = bq_pkg::sat_sample(acc_sh);

  always_ff @(posedge clk) begin
    if (ctl.w_en) begin
      w_r <= bq_pkg::sat_state(w_diff);
    end
    if (ctl.y_en && !ctl.ch) begin
      left_y_r <= y_sat;
    end
  end

  // Shift the delay line of the finished channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw1_r <= '0;
      lw2_r <= '0;
      rw1_r <= '0;
      rw2_r <= '0;
    end else if (ctl.y_en) begin
      if (ctl.ch) begin
        rw2_r <= rw1_r;
        rw1_r <= w_r;
      end else begin
        lw2_r <= lw1_r;
        lw1_r <= w_r;
      end
    end
  end

  // Output register: load on the final step, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_xfer) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= left_y_r;
      out_right_r <= y_sat;
      out_end_r   <= end_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_flt      = out_left_r;
  assign out_ch.right_flt     = out_right_r;
  assign out_ch.block_end_out = out_end_r;

endmodule

// ===== hw/rtl/bq_checker.sv =====
// Port-level checks for the stereo biquad filter, bound to the top level.
module bq_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [bq_pkg::SAMPLE_BITS-1:0]      out_left,
  input logic [bq_pkg::SAMPLE_BITS-1:0]      out_right,
  input logic                                out_end
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An accepted pair occupies the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_ready |=> !in_ready)
    else $error("ready still high after input transfer");

  // With the sequencer idle, a taken result is not followed at once by another
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_ready && in_ready |=> !out_valid)
    else $error("result repeated after output transfer");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right)
        && $stable(out_end))
    else $error("stalled result changed");

endmodule

bind stereo_biquad_iir_df2 bq_checker u_bq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.left_flt),
  .out_right (out_ch.right_flt),
  .out_end   (out_ch.block_end_out)
);

// ===== dv/stereo_biquad_iir_df2_tb.sv =====
// Self-checking testbench for the stereo direct form II biquad filter.
`timescale 1ns / 1ps

module stereo_biquad_iir_df2_tb;

  // Predictor arithmetic runs wide enough to hold a sum of three full products
  localparam int WIDE = 72;
  localparam int QUIET_LIMIT = 2000;
  localparam int END_WAIT = 30;
  localparam int PHASES = 7;
  localparam int PAIRS_PER_PHASE = 210;
  localparam int REPORT_LIMIT = 10;
  localparam int LEFT = 0;
  localparam int RIGHT = 1;

  localparam logic signed [WIDE-1:0] W_HI =
    (WIDE'(1) <<< (bq_pkg::STATE_BITS - 1)) - WIDE'(1);
  localparam logic signed [WIDE-1:0] W_LO = -W_HI - WIDE'(1);
  localparam logic signed [WIDE-1:0] Y_HI =
    (WIDE'(1) <<< (bq_pkg::SAMPLE_BITS - 1)) - WIDE'(1);
  localparam logic signed [WIDE-1:0] Y_LO = -Y_HI - WIDE'(1);

  localparam logic signed [bq_pkg::SAMPLE_BITS-1:0] S_MAX =
    {1'b0, {(bq_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [bq_pkg::SAMPLE_BITS-1:0] S_MIN =
    {1'b1, {(bq_pkg::SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [bq_pkg::SAMPLE_BITS-1:0] S_ODD = {(bq_pkg::SAMPLE_BITS/2){2'b01}};
  localparam logic signed [bq_pkg::SAMPLE_BITS-1:0] S_EVEN = {(bq_pkg::SAMPLE_BITS/2){2'b10}};

  localparam logic [bq_pkg::COEFF_BITS-1:0] C_MAX = {1'b0, {(bq_pkg::COEFF_BITS-1){1'b1}}};
  localparam logic [bq_pkg::COEFF_BITS-1:0] C_MIN = {1'b1, {(bq_pkg::COEFF_BITS-1){1'b0}}};
  localparam logic [bq_pkg::COEFF_BITS-1:0] C_ZERO = '0;
  localparam logic [bq_pkg::COEFF_BITS-1:0] C_ONE =
    bq_pkg::COEFF_BITS'(1) << bq_pkg::COEFF_FRAC_BITS;

  // Low-pass with poles at radius 0.8
  localparam logic [bq_pkg::COEFF_BITS-1:0] LP_A1 = -32'sd429496730;
  localparam logic [bq_pkg::COEFF_BITS-1:0] LP_A2 = 32'sd171798692;
  localparam logic [bq_pkg::COEFF_BITS-1:0] LP_B0 = 32'sd2684355;
  localparam logic [bq_pkg::COEFF_BITS-1:0] LP_B1 = 32'sd5368709;

  typedef struct packed {
    logic signed [bq_pkg::SAMPLE_BITS-1:0] left;
    logic signed [bq_pkg::SAMPLE_BITS-1:0] right;
    logic                                  block_end;
  } sample_pair_t;

  // Tracks coefficients and delay lines, queues the filtered pairs to come
  class biquad_pair_checker;
    logic signed [WIDE-1:0] a1, a2, b0, b1, b2;
    logic signed [WIDE-1:0] w1 [2];
    logic signed [WIDE-1:0] w2 [2];
    sample_pair_t expected_pairs [$];
    int mismatch_count;

    function new();
      a1 = '0;
      a2 = '0;
      b0 = WIDE'(1) <<< bq_pkg::COEFF_FRAC_BITS;
      b1 = '0;
      b2 = '0;
      foreach (w1[i]) begin
        w1[i] = '0;
        w2[i] = '0;
      end
      mismatch_count = 0;
    endfunction

    function void set_coeff(logic [bq_pkg::CFG_IDX_BITS-1:0] idx,
        logic [bq_pkg::COEFF_BITS-1:0] v);
      case (idx)
        bq_pkg::REG_A1: a1 = $signed(v);
        bq_pkg::REG_A2: a2 = $signed(v);
        bq_pkg::REG_B0: b0 = $signed(v);
        bq_pkg::REG_B1: b1 = $signed(v);
        bq_pkg::REG_B2: b2 = $signed(v);
        default: ;
      endcase
    endfunction

    // One DF2 step: floor-scaled sums, clamp w to the state range, y to samples
    function logic signed [bq_pkg::SAMPLE_BITS-1:0] filter_channel(int ch,
        logic signed [bq_pkg::SAMPLE_BITS-1:0] x);
      logic signed [WIDE-1:0] w;
      logic signed [WIDE-1:0] y;
      w = x;
      w = w - ((a1 * w1[ch] + a2 * w2[ch]) >>> bq_pkg::COEFF_FRAC_BITS);
      if (w > W_HI) w = W_HI;
      else if (w < W_LO) w = W_LO;
      y = (b0 * w + b1 * w1[ch] + b2 * w2[ch]) >>> bq_pkg::COEFF_FRAC_BITS;
      if (y > Y_HI) y = Y_HI;
      else if (y < Y_LO) y = Y_LO;
      w2[ch] = w1[ch];
      w1[ch] = w;
      return y[bq_pkg::SAMPLE_BITS-1:0];
    endfunction

    function void note_sample_pair(logic signed [bq_pkg::SAMPLE_BITS-1:0] l,
        logic signed [bq_pkg::SAMPLE_BITS-1:0] r, logic be);
      sample_pair_t e;
      e.left = filter_channel(LEFT, l);
      e.right = filter_channel(RIGHT, r);
      e.block_end = be;
      expected_pairs.push_back(e);
    endfunction

    function void check_filtered_pair(sample_pair_t got);
      sample_pair_t e;
      if (expected_pairs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result with no pending pair: L=%0d R=%0d end=%0b",
                   got.left, got.right, got.block_end);
        return;
      end
      e = expected_pairs.pop_front();
      if (got.left !== e.left || got.right !== e.right || got.block_end !== e.block_end)
      begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("mismatch: expected L=%0d R=%0d end=%0b, got L=%0d R=%0d end=%0b",
                   e.left, e.right, e.block_end, got.left, got.right, got.block_end);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [bq_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [bq_pkg::COEFF_BITS-1:0] cfg_wdata;
  bit idle_on;
  int stall_left;
  int quiet_cycles;
  biquad_pair_checker sb;

  bq_in_if in_if ();
  bq_out_if out_if ();

  stereo_biquad_iir_df2 uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check each result transfer, then pick the next ready with random stall bursts while idle_on is set
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_filtered_pair('{out_if.left_flt, out_if.right_flt, out_if.block_end_out});
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Present one pair, optionally after a gap, and hold it until the transfer
  task automatic send_pair(input logic signed [bq_pkg::SAMPLE_BITS-1:0] l,
      input logic signed [bq_pkg::SAMPLE_BITS-1:0] r, input logic be);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.left_smp <= l;
    in_if.right_smp <= r;
    in_if.block_end_in <= be;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample_pair(l, r, be);
  endtask

  // Drop valid and wait until every pending result has been taken
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_pairs.size() != 0);
  endtask

  task automatic write_reg(input logic [bq_pkg::CFG_IDX_BITS-1:0] idx,
      input logic [bq_pkg::COEFF_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_coeff(idx, v);
  endtask

  // Load all five coefficients plus one write to an unused index
  task automatic load_coeffs(input logic [bq_pkg::COEFF_BITS-1:0] a1, a2, b0, b1, b2);
    write_reg(bq_pkg::REG_A1, a1);
    write_reg(bq_pkg::REG_A2, a2);
    write_reg(bq_pkg::REG_B0, b0);
    write_reg(bq_pkg::REG_B1, b1);
    write_reg(bq_pkg::REG_B2, b2);
    write_reg(bq_pkg::CFG_IDX_BITS'($urandom_range(int'(bq_pkg::REG_B2) + 1,
                                                   (1 << bq_pkg::CFG_IDX_BITS) - 1)),
              $urandom());
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [bq_pkg::COEFF_BITS-1:0] rand_coeff();
    case ($urandom_range(0, 5)) inside
      0: return C_MAX;
      1: return C_MIN;
      2: return C_ZERO;
      3, 4: return bq_pkg::COEFF_BITS'($signed($urandom_range(0, 2 * int'(C_ONE)))
                                       - int'(C_ONE));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [bq_pkg::SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return bq_pkg::SAMPLE_BITS'($signed($urandom_range(0, 2000)) - 1000);
      default: return bq_pkg::SAMPLE_BITS'($urandom());
    endcase
  endfunction

  initial begin
    sb = new();
    idle_on = 1'b1;
    stall_left = 0;
    quiet_cycles = 0;
    in_if.valid = 1'b0;
    in_if.left_smp = '0;
    in_if.right_smp = '0;
    in_if.block_end_in = 1'b0;
    out_if.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = bq_pkg::REG_A1;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Passthrough from reset: sample extremes and bit patterns
    send_pair('0, '0, 1'b0);
    send_pair(S_MAX, S_MIN, 1'b1);
    send_pair(S_MIN, S_MAX, 1'b0);
    send_pair(-1, 1, 1'b0);
    send_pair(S_ODD, S_EVEN, 1'b1);
    send_pair(S_EVEN, S_ODD, 1'b0);
    send_pair(1, -1, 1'b0);
    send_pair('0, '0, 1'b1);
    drain();

    // All coefficients at full scale: drive state and output into saturation
    load_coeffs(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(S_MAX, S_MIN, 1'b1);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(S_MIN, S_MAX, 1'b0);
    send_pair(S_MIN, S_MAX, 1'b1);
    send_pair(S_MIN, S_MAX, 1'b0);
    drain();

    load_coeffs(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_pair(S_MAX, S_MIN, 1'b1);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(S_MIN, S_MAX, 1'b0);
    send_pair(S_MIN, S_MAX, 1'b1);
    send_pair('0, '0, 1'b0);
    send_pair(S_ODD, S_EVEN, 1'b0);
    drain();

    // Zero gains: output stays silent while the state keeps moving
    load_coeffs(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
    send_pair(S_MAX, S_MIN, 1'b1);
    send_pair(S_MIN, S_MAX, 1'b0);
    send_pair(S_EVEN, S_ODD, 1'b1);
    drain();

    // Random phases: a stable low-pass first, then random coefficient sets;
    // the last phase runs without idling on either side
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0)
        load_coeffs(LP_A1, LP_A2, LP_B0, LP_B1, LP_B0);
      else
        load_coeffs(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
      idle_on = (phase != PHASES - 1);
      for (int n = 0; n < PAIRS_PER_PHASE; n++)
        send_pair(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
      drain();
    end

    repeat (END_WAIT) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_pairs.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
